// ===== design/rcr_pkg.sv =====
// ----------------------------------------------------------------------------
// rcr_pkg: shared definitions for the random core repartitioner
// Field widths, op and error codes, register map, LCG constants and the
// result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package rcr_pkg;

  // Field widths of the input and result words
  localparam int OP_W   = 2;
  localparam int SLOT_W = 3;
  localparam int CORE_W = 4;
  localparam int ERR_W  = 2;

  // Op codes
  localparam logic [OP_W-1:0] OP_ADMIT   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SLOT   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NOSLOT = 2'd2;

  // Register map: index is paddr[2]
  localparam int          ADDR_W    = 3;
  localparam int          DATA_W    = 32;
  localparam int          CORES_W   = 5;
  localparam logic        REG_CORES = 1'b0;
  localparam logic        REG_SEED  = 1'b1;
  localparam logic [CORES_W-1:0] CORES_RST = 5'd16;
  localparam logic [31:0]        SEED_RST  = 32'd1;

  // Generator: state = state * LCG_MUL + LCG_INC, draw = state >> DRAW_SHIFT
  localparam logic [31:0] LCG_MUL     = 32'd1103515245;
  localparam logic [31:0] LCG_INC     = 32'd12345;
  localparam int          DRAW_SHIFT  = 16;
  localparam int          DRAW_W      = 32 - DRAW_SHIFT;
  localparam int          DRAW_DIGITS = 4;   // draw bits consumed per cycle

  // Default sizes
  localparam int MAX_CORES_DEF = 16;
  localparam int MAX_SLOTS_DEF = 8;

  typedef struct packed {
    logic [CORE_W-1:0] core;
    logic [SLOT_W-1:0] owner;
    logic              owned;
    logic              moved;
    logic [ERR_W-1:0]  err;
    logic              last;
  } rcr_res_t;

endpackage

`default_nettype wire

// ===== design/rcr_draw_unit.sv =====
// ----------------------------------------------------------------------------
// rcr_draw_unit: random draw and remainder unit
// Advances the 32-bit LCG once per request, then reduces the 16-bit draw
// modulo a small divisor, a few bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcr_draw_unit #(
  parameter int DIV_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             seed_load,
  input  wire logic [31:0]      seed,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  busy,
  output logic [DIV_W-1:0]      rem
);

  localparam int NSTEP  = rcr_pkg::DRAW_W / rcr_pkg::DRAW_DIGITS;
  localparam int STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  logic [31:0]                     lcg_state;
  logic [DIV_W-1:0]                div_r;
  logic [STEP_W-1:0]               step_cnt;
  logic [rcr_pkg::DRAW_DIGITS-1:0] chunk;
  logic [DIV_W-1:0]                rem_next;

  // Draw bits, most significant first
  assign chunk = lcg_state[rcr_pkg::DRAW_SHIFT + rcr_pkg::DRAW_W - 1
                           - rcr_pkg::DRAW_DIGITS * int'(step_cnt)
                           -: rcr_pkg::DRAW_DIGITS];

  // Restoring remainder over one chunk
  always_comb begin
    logic [DIV_W:0] t;
    rem_next = rem;
    for (int j = 0; j < rcr_pkg::DRAW_DIGITS; j++) begin
      t = {rem_next, chunk[rcr_pkg::DRAW_DIGITS-1-j]};
      if (t >= {1'b0, div_r}) begin
        rem_next = DIV_W'(t - {1'b0, div_r});
      end else begin
        rem_next = t[DIV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= rcr_pkg::SEED_RST;
      busy      <= 1'b0;
      step_cnt  <= '0;
    end else if (seed_load) begin
      lcg_state <= seed;
    end else if (start) begin
      lcg_state <= lcg_state * rcr_pkg::LCG_MUL + rcr_pkg::LCG_INC;
      busy      <= 1'b1;
      step_cnt  <= '0;
    end else if (busy) begin
      step_cnt <= step_cnt + 1'b1;
      if (int'(step_cnt) == NSTEP - 1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem   <= '0;
    end else if (busy) begin
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/rcr_out_buf.sv =====
// ----------------------------------------------------------------------------
// rcr_out_buf: result output register
// Holds one result word toward the consumer; takes a new word when empty or
// when the held word leaves in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcr_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rcr_pkg::rcr_res_t data,
  output logic                  can_take,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rcr_pkg::rcr_res_t     out_data
);

  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && push) begin
      out_data <= data;
    end
  end

endmodule

`default_nettype wire

// ===== design/random_core_repartitioner.sv =====
// ----------------------------------------------------------------------------
// random_core_repartitioner: random equipartitioning of worker cores
// Assigns worker cores 2 .. cores_in_use-1 to program slots, admitting and
// releasing slots with LCG-driven random moves, one result word per move.
// ----------------------------------------------------------------------------
// Usage and timing: one input word is taken at a time; in_ready is high only
// while the sequencer is idle. A read op goes straight to the final state and
// leaves once the output register can take it. An admit walks worker cores
// 2 .. n-1 (n = min(cores_in_use, MAX_CORES)): a core is taken without a draw
// when it is idle or no program is running; a busy core needs a draw. A
// release walks all MAX_CORES entries: a core not owned by the slot, dropped,
// or left unowned takes no draw; a core redistributed to a remaining slot
// needs one. Each walk ends by finding the end of the walk and then handing
// over the last word. Every random draw uses the shared draw unit: one LCG
// step (a 32x32 multiply) followed by the remainder, four draw bits per
// cycle. Results pass through an output register, so the next word's walk
// proceeds while an earlier result waits, stalling only when a second result
// is ready to leave. The last result of each admit, release or read carries
// last=1; the sequencer keeps one result in hand so it can mark it. Writing
// random_seed reloads the generator state at once; write configuration only
// while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module random_core_repartitioner #(
  parameter int MAX_CORES = rcr_pkg::MAX_CORES_DEF,
  parameter int MAX_SLOTS = rcr_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // APB-style configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rcr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rcr_pkg::DATA_W-1:0]  pwdata,
  output logic [rcr_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rcr_pkg::OP_W-1:0]    op,
  input  wire logic [rcr_pkg::SLOT_W-1:0]  slot,
  input  wire logic [rcr_pkg::CORE_W-1:0]  core,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rcr_pkg::CORE_W-1:0]       core_res,
  output logic [rcr_pkg::SLOT_W-1:0]       owner_slot,
  output logic                             owned,
  output logic                             moved,
  output logic [rcr_pkg::ERR_W-1:0]        error,
  output logic                             last
);

  // Core index, core counter, running count and divisor widths
  localparam int CIW   = $clog2(MAX_CORES);
  localparam int CNW   = $clog2(MAX_CORES + 1);
  localparam int RCW   = $clog2(MAX_SLOTS + 1);
  localparam int DVW   = $clog2(MAX_SLOTS + 2);
  // Only slots reachable through the slot field can ever be active
  localparam int NSRCH = (MAX_SLOTS < (1 << rcr_pkg::SLOT_W)) ?
                         MAX_SLOTS : (1 << rcr_pkg::SLOT_W);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  // Configuration registers
  logic [rcr_pkg::CORES_W-1:0] cores_in_use;
  logic [31:0]                 random_seed;
  logic                        cfg_wr;

  // Allocation state
  logic [rcr_pkg::SLOT_W-1:0] core_owner [MAX_CORES];
  logic [MAX_CORES-1:0]       core_valid;
  logic [MAX_SLOTS-1:0]       slot_active;
  logic [RCW-1:0]             running_count;

  // Sequencer registers
  logic [1:0]                 state;
  logic [1:0]                 state_next;
  logic [rcr_pkg::OP_W-1:0]   op_r;
  logic [rcr_pkg::SLOT_W-1:0] slot_r;
  logic [CNW-1:0]             idx;
  logic [CNW-1:0]             n_r;
  logic [RCW-1:0]             run_r;
  logic                       pend_v;
  rcr_pkg::rcr_res_t          pend;

  // Table access
  logic [CIW-1:0]             rd_addr;
  logic [rcr_pkg::SLOT_W-1:0] rd_owner;
  logic                       rd_valid;
  logic                       tbl_we;
  logic                       tbl_wv;
  logic [rcr_pkg::SLOT_W-1:0] tbl_wo;

  // Sequencer decisions
  logic              seq_emit;
  rcr_pkg::rcr_res_t nres;
  logic              adv;
  logic              draw_start;
  logic              fin_push;
  logic              stall;
  logic              go;

  // Draw unit and output register
  logic              draw_busy;
  logic [DVW-1:0]    draw_rem;
  logic [DVW-1:0]    draw_div;
  logic              buf_push;
  logic              buf_can_take;
  rcr_pkg::rcr_res_t buf_data;
  rcr_pkg::rcr_res_t out_word;

  // Release target search
  logic [rcr_pkg::SLOT_W-1:0] chosen;
  logic                       found;

  // Input decode
  logic                 in_fire;
  logic [MAX_SLOTS-1:0] slot_mask;
  logic                 slot_bad_admit;
  logic                 slot_bad_release;
  logic                 core_ok;
  logic [CNW-1:0]       n_in;

  // --------------------------------------------------------------------------
  // Configuration port: always ready, register index from paddr[2]
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cores_in_use <= rcr_pkg::CORES_RST;
      random_seed  <= rcr_pkg::SEED_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == rcr_pkg::REG_CORES) begin
        cores_in_use <= pwdata[rcr_pkg::CORES_W-1:0];
      end else begin
        random_seed <= pwdata[31:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == rcr_pkg::REG_SEED) begin
      prdata = random_seed;
    end else begin
      prdata = rcr_pkg::DATA_W'(cores_in_use);
    end
  end

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  assign in_ready         = (state == S_IDLE);
  assign in_fire          = in_valid && in_ready;
  // an out-of-range slot shifts out of the mask and leaves it empty
  assign slot_mask        = MAX_SLOTS'(1) << slot;
  assign slot_bad_admit   = (slot_mask == '0) || ((slot_active & slot_mask) != '0);
  assign slot_bad_release = (slot_mask == '0) || ((slot_active & slot_mask) == '0);
  assign core_ok          = (32'(core) < 32'(MAX_CORES));
  // clamp the managed core count to the table size
  assign n_in             = (32'(cores_in_use) > 32'(MAX_CORES)) ?
                            CNW'(MAX_CORES) : CNW'(cores_in_use);

  // --------------------------------------------------------------------------
  // Owner table: one read address, the input core while idle, else the walk
  // --------------------------------------------------------------------------
  assign rd_addr  = (state == S_IDLE) ? CIW'(core) : idx[CIW-1:0];
  assign rd_owner = core_owner[rd_addr];
  assign rd_valid = core_valid[rd_addr];

  always_ff @(posedge clk) begin
    if (go && tbl_we) begin
      core_owner[idx[CIW-1:0]] <= tbl_wo;
    end
  end

  // --------------------------------------------------------------------------
  // Release target: the pick-th active slot in ascending slot order
  // --------------------------------------------------------------------------
  always_comb begin
    logic [DVW-1:0] seen;
    seen   = '0;
    chosen = '0;
    found  = 1'b0;
    for (int t = 0; t < NSRCH; t++) begin
      if (slot_active[t] && !found) begin
        if (seen == draw_rem) begin
          chosen = rcr_pkg::SLOT_W'(t);
          found  = 1'b1;
        end
        seen = seen + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer decisions for the current core of the walk
  // --------------------------------------------------------------------------
  always_comb begin
    seq_emit   = 1'b0;
    nres       = '0;
    tbl_we     = 1'b0;
    tbl_wv     = 1'b0;
    tbl_wo     = '0;
    adv        = 1'b0;
    draw_start = 1'b0;
    draw_div   = '0;
    fin_push   = 1'b0;
    state_next = state;

    case (state)
      S_SCAN: begin
        if (op_r == rcr_pkg::OP_ADMIT) begin
          if (idx >= n_r) begin
            state_next = S_FINAL;
          end else if (run_r == '0 || !rd_valid) begin
            // idle core, or the first program: take it without a draw
            seq_emit   = 1'b1;
            nres.core  = rcr_pkg::CORE_W'(idx);
            nres.owner = slot_r;
            nres.owned = 1'b1;
            nres.moved = 1'b1;
            nres.err   = rcr_pkg::ERR_OK;
            tbl_we     = 1'b1;
            tbl_wv     = 1'b1;
            tbl_wo     = slot_r;
            adv        = 1'b1;
          end else begin
            // busy core moves with chance 1/(running+1)
            draw_start = 1'b1;
            draw_div   = DVW'(run_r) + 1'b1;
            state_next = S_WAIT;
          end
        end else begin
          if (32'(idx) == 32'(MAX_CORES)) begin
            state_next = S_FINAL;
          end else if (!(rd_valid && rd_owner == slot_r)) begin
            adv = 1'b1;
          end else if (idx < CNW'(2) || idx >= n_r) begin
            // reserved or unmanaged core: drop it silently
            tbl_we = 1'b1;
            adv    = 1'b1;
          end else if (run_r == '0) begin
            // last program left: the core goes unowned
            seq_emit   = 1'b1;
            nres.core  = rcr_pkg::CORE_W'(idx);
            nres.moved = 1'b1;
            nres.err   = rcr_pkg::ERR_NOSLOT;
            tbl_we     = 1'b1;
            adv        = 1'b1;
          end else begin
            draw_start = 1'b1;
            draw_div   = DVW'(run_r);
            state_next = S_WAIT;
          end
        end
      end

      S_WAIT: begin
        if (!draw_busy) begin
          adv        = 1'b1;
          state_next = S_SCAN;
          if (op_r == rcr_pkg::OP_ADMIT) begin
            if (draw_rem == '0) begin
              seq_emit   = 1'b1;
              nres.core  = rcr_pkg::CORE_W'(idx);
              nres.owner = slot_r;
              nres.owned = 1'b1;
              nres.moved = 1'b1;
              nres.err   = rcr_pkg::ERR_OK;
              tbl_we     = 1'b1;
              tbl_wv     = 1'b1;
              tbl_wo     = slot_r;
            end
          end else begin
            seq_emit   = 1'b1;
            nres.core  = rcr_pkg::CORE_W'(idx);
            nres.moved = 1'b1;
            tbl_we     = 1'b1;
            if (found) begin
              nres.owner = chosen;
              nres.owned = 1'b1;
              nres.err   = rcr_pkg::ERR_OK;
              tbl_wv     = 1'b1;
              tbl_wo     = chosen;
            end else begin
              nres.err = rcr_pkg::ERR_NOSLOT;
            end
          end
        end
      end

      S_FINAL: begin
        fin_push = 1'b1;
        if (buf_can_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = state;
      end
    endcase
  end

  // Hold the walk when a new result needs the held one to leave and it cannot
  assign stall = seq_emit && pend_v && !buf_can_take;
  assign go    = !stall;

  // Output word: the held result, marked last on the final push; a walk that
  // moved nothing reports the input slot with no move
  always_comb begin
    buf_push = fin_push || (seq_emit && pend_v && go);
    buf_data = pend;
    if (fin_push) begin
      if (pend_v) begin
        buf_data.last = 1'b1;
      end else begin
        buf_data.core  = '0;
        buf_data.owner = slot_r;
        buf_data.owned = 1'b0;
        buf_data.moved = 1'b0;
        buf_data.err   = rcr_pkg::ERR_OK;
        buf_data.last  = 1'b1;
      end
    end else begin
      buf_data.last = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and allocation state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      core_valid    <= '0;
      slot_active   <= '0;
      running_count <= '0;
      pend_v        <= 1'b0;
    end else begin
      if (go && !in_fire) begin
        state <= state_next;
      end
      if (go && tbl_we) begin
        core_valid[idx[CIW-1:0]] <= tbl_wv;
      end
      if (go && seq_emit) begin
        pend_v <= 1'b1;
      end
      if (fin_push && buf_can_take) begin
        pend_v <= 1'b0;
      end
      if (in_fire) begin
        case (op)
          rcr_pkg::OP_READ: begin
            pend_v <= 1'b1;
            state  <= S_FINAL;
          end
          rcr_pkg::OP_ADMIT: begin
            if (slot_bad_admit) begin
              pend_v <= 1'b1;
              state  <= S_FINAL;
            end else begin
              slot_active   <= slot_active | slot_mask;
              running_count <= running_count + 1'b1;
              state         <= S_SCAN;
            end
          end
          rcr_pkg::OP_RELEASE: begin
            if (slot_bad_release) begin
              pend_v <= 1'b1;
              state  <= S_FINAL;
            end else begin
              slot_active <= slot_active & ~slot_mask;
              if (running_count != '0) begin
                running_count <= running_count - 1'b1;
              end
              state <= S_SCAN;
            end
          end
          default: begin
            // unused op: drop the word, no result
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // Payload side of the sequencer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= op;
      slot_r <= slot;
      n_r    <= n_in;
      if (op == rcr_pkg::OP_ADMIT) begin
        idx   <= CNW'(2);
        run_r <= running_count;
      end else begin
        idx   <= '0;
        run_r <= (running_count != '0) ? running_count - 1'b1 : '0;
      end
      // direct results: owner read or bad slot
      pend.last <= 1'b0;
      if (op == rcr_pkg::OP_READ) begin
        pend.core  <= core;
        pend.owner <= (core_ok && rd_valid) ? rd_owner : '0;
        pend.owned <= core_ok && rd_valid;
        pend.moved <= 1'b0;
        pend.err   <= rcr_pkg::ERR_OK;
      end else begin
        pend.core  <= '0;
        pend.owner <= slot;
        pend.owned <= 1'b0;
        pend.moved <= 1'b0;
        pend.err   <= rcr_pkg::ERR_SLOT;
      end
    end else begin
      if (go && adv) begin
        idx <= idx + 1'b1;
      end
      if (go && seq_emit) begin
        pend <= nres;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared draw unit and output register
  // --------------------------------------------------------------------------
  rcr_draw_unit #(
    .DIV_W (DVW)
  ) u_draw (
    .clk       (clk),
    .rst       (rst),
    .seed_load (cfg_wr && paddr[2] == rcr_pkg::REG_SEED),
    .seed      (pwdata[31:0]),
    .start     (draw_start),
    .divisor   (draw_div),
    .busy      (draw_busy),
    .rem       (draw_rem)
  );

  rcr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (buf_push),
    .data      (buf_data),
    .can_take  (buf_can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_word)
  );

  assign core_res   = out_word.core;
  assign owner_slot = out_word.owner;
  assign owned      = out_word.owned;
  assign moved      = out_word.moved;
  assign error      = out_word.err;
  assign last       = out_word.last;

endmodule

`default_nettype wire
